@@ hdl/tdpf_pkg.sv @@
// Shared types and constants for the trial-division prime factorizer.
// Holds the controller/datapath command and status structs and the emit select codes.
// No dependencies.
`timescale 1ns / 1ps

package tdpf_pkg;

    // Width of the value and factor fields on the ports.
    localparam int FIELD_WIDTH = 32;

    // Default number of value bits that take part in factoring.
    localparam int VALUE_WIDTH_DEF = 32;

    // Source of the factor written to the output register.
    typedef enum logic [1:0] {
        EMIT_ZERO,
        EMIT_DIVISOR,
        EMIT_REMAINDER
    } t_emit_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      square;
        logic      div_start;
        logic      take_quot;
        logic      next_div;
        logic      emit;
        t_emit_sel emit_sel;
        logic      emit_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rem_lt2;
        logic sq_gt;
        logic div_busy;
        logic part_zero;
        logic out_free;
    } t_sts;

endpackage

@@ hdl/tdpf_if.sv @@
// Valid/ready channel interfaces for the trial-division prime factorizer.
// Depends on tdpf_pkg for the field width.
`timescale 1ns / 1ps

// Channel that carries one value word to factor.
interface tdpf_value_if;
    import tdpf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// Channel that carries one factor word and its last flag.
interface tdpf_result_if;
    import tdpf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] factor;
    logic                   last;

    modport source (output valid, output factor, output last, input ready);
    modport sink   (input valid, input factor, input last, output ready);
endinterface

@@ hdl/tdpf_dp.sv @@
// Datapath of the trial-division prime factorizer: remainder, divisor, squarer,
// bit-serial restoring divider and the output register. Depends on tdpf_pkg.
`timescale 1ns / 1ps

module tdpf_dp #(
    parameter int REM_WIDTH = tdpf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [tdpf_pkg::FIELD_WIDTH-1:0] i_value,
    input  tdpf_pkg::t_cmd                   i_cmd,
    output tdpf_pkg::t_sts                   o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [tdpf_pkg::FIELD_WIDTH-1:0] o_factor,
    output logic                             o_last
);
    import tdpf_pkg::*;

    // The divisor never exceeds the square root of the remainder plus one.
    localparam int DIV_WIDTH = (REM_WIDTH + 1) / 2 + 1;
    localparam int SQ_WIDTH  = 2 * DIV_WIDTH;
    localparam int CNT_WIDTH = $clog2(REM_WIDTH + 1);

    logic [REM_WIDTH-1:0]   r_rem;
    logic [DIV_WIDTH-1:0]   r_div;
    logic [SQ_WIDTH-1:0]    r_sq;
    logic [REM_WIDTH-1:0]   r_quo;
    logic [DIV_WIDTH:0]     r_part;
    logic [CNT_WIDTH-1:0]   r_cnt;
    logic                   r_busy;
    logic                   r_out_valid;
    logic [FIELD_WIDTH-1:0] r_out_factor;
    logic                   r_out_last;

    logic [DIV_WIDTH:0]     w_shift;
    logic [DIV_WIDTH+1:0]   w_diff;
    logic                   w_ge;
    logic [FIELD_WIDTH-1:0] n_factor;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    assign w_shift = {r_part[DIV_WIDTH-1:0], r_quo[REM_WIDTH-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};
    assign w_ge    = ~w_diff[DIV_WIDTH+1];

    // Remainder, divisor and divider control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_div  <= DIV_WIDTH'(2);
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_rem <= i_value[REM_WIDTH-1:0];
                r_div <= DIV_WIDTH'(2);
            end else begin
                if (i_cmd.take_quot) begin
                    r_rem <= r_quo;
                end
                if (i_cmd.next_div) begin
                    r_div <= r_div + DIV_WIDTH'(1);
                end
            end
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_WIDTH'(REM_WIDTH);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - CNT_WIDTH'(1);
                r_busy <= (r_cnt != CNT_WIDTH'(1));
            end
        end
    end

    // Payload side of the squarer and divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sq <= r_div * r_div;
        end
        if (i_cmd.div_start) begin
            r_quo  <= r_rem;
            r_part <= '0;
        end else if (r_busy) begin
            r_quo  <= {r_quo[REM_WIDTH-2:0], w_ge};
            r_part <= w_ge ? w_diff[DIV_WIDTH:0] : w_shift;
        end
    end

    // Select the factor to emit.
    always_comb begin
        case (i_cmd.emit_sel)
            EMIT_DIVISOR:   n_factor = FIELD_WIDTH'(r_div);
            EMIT_REMAINDER: n_factor = FIELD_WIDTH'(r_rem);
            default:        n_factor = '0;
        endcase
    end

    // Output register; it frees itself when the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_factor <= n_factor;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    // Status back to the controller.
    assign o_sts.rem_lt2   = (r_rem < REM_WIDTH'(2));
    assign o_sts.sq_gt     = (r_sq > SQ_WIDTH'(r_rem));
    assign o_sts.div_busy  = r_busy;
    assign o_sts.part_zero = (r_part == '0);
    assign o_sts.out_free  = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_factor    = r_out_factor;
    assign o_last      = r_out_last;

endmodule

@@ hdl/tdpf_ctrl.sv @@
// Controller of the trial-division prime factorizer: sequences load, square test,
// division and emit steps. Depends on tdpf_pkg.
`timescale 1ns / 1ps

module tdpf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tdpf_pkg::t_sts i_sts,
    output tdpf_pkg::t_cmd o_cmd
);
    import tdpf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SQUARE,
        S_COMPARE,
        S_DIVIDE,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_emit_sel r_sel;
    t_emit_sel n_sel;
    logic      r_last;
    logic      n_last;

    // Next state and the commands of the current step.
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.emit_sel  = r_sel;
        o_cmd.emit_last = r_last;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                // Zero and one have no prime factors; report a single zero.
                if (i_sts.rem_lt2) begin
                    n_sel   = EMIT_ZERO;
                    n_last  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_COMPARE;
            end
            S_COMPARE: begin
                // Once the divisor squared passes the remainder, the remainder is prime.
                if (i_sts.sq_gt) begin
                    n_sel   = EMIT_REMAINDER;
                    n_last  = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (!i_sts.div_busy) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.part_zero) begin
                    n_sel   = EMIT_DIVISOR;
                    n_last  = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_SQUARE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.take_quot = (r_sel == EMIT_DIVISOR);
                    n_state         = r_last ? S_IDLE : S_SQUARE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered emit selection.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= EMIT_ZERO;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_last  <= n_last;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ hdl/trial_division_prime_factorizer_unit.sv @@
// Trial-division prime factorizer: one value word in, its prime factors out in
// ascending order. Each trial divisor takes a square, compare, bit-serial division
// and decide step; each factor found adds an emit step that waits for a free output register.
// A 32-bit prime needs about 65536 trials; small factors finish fast.
// One value is worked on at a time; the next is taken once the last factor is registered.
// Synchronous active-low reset clears the controller and empties the output register.
`timescale 1ns / 1ps

module trial_division_prime_factorizer_unit #(
    parameter int VALUE_WIDTH = tdpf_pkg::VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdpf_value_if.sink    i_value,
    tdpf_result_if.source o_result
);
    import tdpf_pkg::*;

    // Bits of the value that take part: the port width caps the parameter.
    localparam int REM_WIDTH = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    tdpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_value.valid),
        .o_in_ready (i_value.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and output register.
    tdpf_dp #(
        .REM_WIDTH (REM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value.value),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_factor    (o_result.factor),
        .o_last      (o_result.last)
    );

endmodule

@@ hdl/tdpf_checker.sv @@
// Port-level checks for the trial-division prime factorizer, bound to the top level.
// Depends on tdpf_pkg and trial_division_prime_factorizer_unit.
`timescale 1ns / 1ps

module tdpf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [tdpf_pkg::FIELD_WIDTH-1:0] i_factor,
    input logic                             i_last
);
    import tdpf_pkg::*;

    // A word taken starts work, so the input closes on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still ready right after a word was taken");

    // A zero factor only reports an input below two and is always the last.
    a_zero_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_factor == '0)) |-> i_last)
        else $error("zero factor without last");

    // A factor that is not the last is a real divisor of at least two.
    a_mid_factor_ge2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last) |-> (i_factor >= FIELD_WIDTH'(2)))
        else $error("non-final factor below two");

    // A stalled result word holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_factor) && $stable(i_last)))
        else $error("result word changed while stalled");

endmodule

bind trial_division_prime_factorizer_unit tdpf_checker u_tdpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_value.valid),
    .i_in_ready  (i_value.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_factor    (o_result.factor),
    .i_last      (o_result.last)
);
